/* src/mshu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mshu_pkg
// Shared types and constants for the mod set multiset hash unit.
// ----------------------------------------------------------------------------
package mshu_pkg;

   localparam logic [63:0] FNV_OFFSET = 64'hCBF2_9CE4_8422_2325;
   localparam logic [7:0]  SEP_BYTE   = 8'h1F;
   localparam logic [63:0] MIX_K1     = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [63:0] MIX_K2     = 64'h94D0_49BB_1331_11EB;
   localparam int          CNT_W      = 9;

   typedef enum logic [1:0] {
      OP_NAME    = 2'd0,
      OP_VER     = 2'd1,
      OP_END_REC = 2'd2,
      OP_END_SET = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_NAME,
      CMD_SEP,
      CMD_VER,
      CMD_VER_HELD,
      CMD_LOAD,
      CMD_MLL,
      CMD_MHL,
      CMD_MLH,
      CMD_MIX,
      CMD_ADD,
      CMD_SET_END
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       k_sel;
      logic       capture;
   } cmd_type;

   typedef struct packed {
      logic in_ver;
      logic incl;
   } sts_type;

   // FNV-1a step; prime 2^40 + 0x1B3 done as shift-add
   function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage
`default_nettype wire

/* src/mshu_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mshu_req_if
// Input channel: one op with its byte and enable flag per transfer.
// ----------------------------------------------------------------------------
interface mshu_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;
   logic       mod_enabled;

   modport source (output valid, output op, output data_byte, output mod_enabled,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input mod_enabled,
                   output ready);
endinterface
`default_nettype wire

/* src/mshu_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mshu_rsp_if
// Result channel: set hash and included record count per transfer.
// ----------------------------------------------------------------------------
interface mshu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] set_hash;
   logic [8:0]  records_included;

   modport source (output valid, output set_hash, output records_included,
                   input ready);
   modport sink   (input valid, input set_hash, input records_included,
                   output ready);
endinterface
`default_nettype wire

/* src/mod_set_multiset_hash_unit.sv */
`default_nettype none
// First version byte: separator folded, then the held byte in ST_VER; other bytes
// fold on acceptance. End of record: ST_LOAD, then, if included, MLL, MHL, MLH, MIX,
// MLL, MHL, MLH, ADD (two rounds of three 32x32 partial products on one shared
// multiplier). End of set: result registered the next cycle; held until taken.
// Reset: synchronous, active high; clears sum, counters and record state.
// ----------------------------------------------------------------------------
// mod_set_multiset_hash_unit
// Order-independent FNV-1a/splitmix64 hash of a set of name/version records.
// ----------------------------------------------------------------------------
module mod_set_multiset_hash_unit #(
   parameter int MAX_MODS = 256
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mshu_req_if.sink   req_chan,
   mshu_rsp_if.source rsp_chan
);
   import mshu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mshu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.op),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   mshu_dp #(
      .MAX_MODS (MAX_MODS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .data_byte        (req_chan.data_byte),
      .mod_enabled      (req_chan.mod_enabled),
      .set_hash         (rsp_chan.set_hash),
      .records_included (rsp_chan.records_included)
   );

endmodule
`default_nettype wire

/* src/mshu_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mshu_ctrl
// Sequencer: issues fold, finalizer and set-end commands to the datapath.
// ----------------------------------------------------------------------------
module mshu_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_op,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mshu_pkg::cmd_type     cmd,
   input  wire mshu_pkg::sts_type sts
);
   import mshu_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_VER  = 8'b0000_0010,
      ST_LOAD = 8'b0000_0100,
      ST_MLL  = 8'b0000_1000,
      ST_MHL  = 8'b0001_0000,
      ST_MLH  = 8'b0010_0000,
      ST_MIX  = 8'b0100_0000,
      ST_ADD  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      round_ff, round_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   op_type    op;

   assign op        = op_type'(req_op);
   assign req_ready = (state_ff == ST_IDLE) && !(rsp_valid_ff && !rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = CMD_NONE;
      cmd.k_sel    = round_ff;
      cmd.capture  = req_fire;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op)
                  OP_NAME: begin
                     cmd.op = CMD_NAME;
                  end
                  OP_VER: begin
                     if (sts.in_ver) begin
                        cmd.op = CMD_VER;
                     end else begin
                        cmd.op   = CMD_SEP;
                        state_in = ST_VER;
                     end
                  end
                  OP_END_REC: begin
                     if (!sts.in_ver) begin
                        cmd.op = CMD_SEP;
                     end
                     state_in = ST_LOAD;
                  end
                  OP_END_SET: begin
                     cmd.op       = CMD_SET_END;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     cmd.op = CMD_NONE;
                  end
               endcase
            end
         end
         ST_VER: begin
            cmd.op   = CMD_VER_HELD;
            state_in = ST_IDLE;
         end
         ST_LOAD: begin
            cmd.op   = CMD_LOAD;
            round_in = 1'b0;
            state_in = sts.incl ? ST_MLL : ST_IDLE;
         end
         ST_MLL: begin
            cmd.op   = CMD_MLL;
            state_in = ST_MHL;
         end
         ST_MHL: begin
            cmd.op   = CMD_MHL;
            state_in = ST_MLH;
         end
         ST_MLH: begin
            cmd.op   = CMD_MLH;
            state_in = round_ff ? ST_ADD : ST_MIX;
         end
         ST_MIX: begin
            cmd.op   = CMD_MIX;
            round_in = 1'b1;
            state_in = ST_MLL;
         end
         ST_ADD: begin
            cmd.op   = CMD_ADD;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");

   a_skip_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && !sts.incl) |=> (state_ff == ST_IDLE))
      else $error("excluded record entered finalizer");

   a_second_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX) |=> (state_ff == ST_MLL && round_ff))
      else $error("second multiply round not started");

   a_set_end_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && op == OP_END_SET) |=> rsp_valid_ff)
      else $error("set end without result");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |=> !$past(req_fire))
      else $error("transfer accepted during finalize");

endmodule
`default_nettype wire

/* src/mshu_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mshu_dp
// Datapath: record hash, shared 32x32 multiplier for the finalizer, set sum.
// ----------------------------------------------------------------------------
module mshu_dp #(
   parameter int MAX_MODS = 256
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mshu_pkg::cmd_type cmd,
   output mshu_pkg::sts_type      sts,
   input  wire logic [7:0]        data_byte,
   input  wire logic              mod_enabled,
   output logic [63:0]            set_hash,
   output logic [8:0]             records_included
);
   import mshu_pkg::*;

   localparam int SEEN_W = $clog2(MAX_MODS + 1);

   logic [63:0]       hash_ff, hash_in;
   logic [63:0]       sum_ff, sum_in;
   logic              in_ver_ff, in_ver_in;
   logic              ne_ff, ne_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [CNT_W-1:0]  incl_cnt_ff, incl_cnt_in;
   logic [63:0]       x_ff, x_in;
   logic [63:0]       acc_ff, acc_in;
   logic [7:0]        byte_ff;
   logic              en_ff;
   logic [63:0]       hash_out_ff;
   logic [8:0]        cnt_out_ff;
   logic [63:0]       k;
   logic [31:0]       mul_a, mul_b;
   logic [63:0]       prod;
   logic              below_max;

   assign k         = cmd.k_sel ? MIX_K2 : MIX_K1;
   assign below_max = seen_ff < SEEN_W'(MAX_MODS);
   assign sts       = '{in_ver: in_ver_ff, incl: en_ff && ne_ff && below_max};

   always_comb begin
      mul_a = x_ff[31:0];
      mul_b = k[31:0];
      case (cmd.op)
         CMD_MHL: mul_a = x_ff[63:32];
         CMD_MLH: mul_b = k[63:32];
         default: mul_a = x_ff[31:0];
      endcase
   end

   assign prod = {32'd0, mul_a} * {32'd0, mul_b};

   always_comb begin
      hash_in     = hash_ff;
      sum_in      = sum_ff;
      in_ver_in   = in_ver_ff;
      ne_in       = ne_ff;
      seen_in     = seen_ff;
      incl_cnt_in = incl_cnt_ff;
      x_in        = x_ff;
      acc_in      = acc_ff;
      case (cmd.op)
         CMD_NAME: begin
            if (!in_ver_ff) begin
               hash_in = fnv_fold(hash_ff, data_byte);
               ne_in   = 1'b1;
            end
         end
         CMD_SEP: begin
            hash_in   = fnv_fold(hash_ff, SEP_BYTE);
            in_ver_in = 1'b1;
         end
         CMD_VER:      hash_in = fnv_fold(hash_ff, data_byte);
         CMD_VER_HELD: hash_in = fnv_fold(hash_ff, byte_ff);
         CMD_LOAD: begin
            x_in      = hash_ff ^ (hash_ff >> 30);
            hash_in   = FNV_OFFSET;
            in_ver_in = 1'b0;
            ne_in     = 1'b0;
            if (below_max) begin
               seen_in = seen_ff + SEEN_W'(1);
            end
         end
         CMD_MLL: acc_in = prod;
         CMD_MHL, CMD_MLH: begin
            acc_in = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
         end
         CMD_MIX: x_in = acc_ff ^ (acc_ff >> 27);
         CMD_ADD: begin
            sum_in      = sum_ff + (acc_ff ^ (acc_ff >> 31));
            incl_cnt_in = incl_cnt_ff + CNT_W'(1);
         end
         CMD_SET_END: begin
            hash_in     = FNV_OFFSET;
            sum_in      = '0;
            in_ver_in   = 1'b0;
            ne_in       = 1'b0;
            seen_in     = '0;
            incl_cnt_in = '0;
         end
         default: begin
            hash_in = hash_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff     <= FNV_OFFSET;
         sum_ff      <= '0;
         in_ver_ff   <= 1'b0;
         ne_ff       <= 1'b0;
         seen_ff     <= '0;
         incl_cnt_ff <= '0;
      end else begin
         hash_ff     <= hash_in;
         sum_ff      <= sum_in;
         in_ver_ff   <= in_ver_in;
         ne_ff       <= ne_in;
         seen_ff     <= seen_in;
         incl_cnt_ff <= incl_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
      if (cmd.capture) begin
         byte_ff <= data_byte;
         en_ff   <= mod_enabled;
      end
      if (cmd.op == CMD_SET_END) begin
         hash_out_ff <= sum_ff;
         cnt_out_ff  <= incl_cnt_ff;
      end
   end

   assign set_hash         = hash_out_ff;
   assign records_included = cnt_out_ff;

endmodule
`default_nettype wire
